[rtl/midi_note_pairing_engine_defines.svh]
// Assertion macros for the MIDI note pairing engine.
`ifndef MIDI_NOTE_PAIRING_ENGINE_DEFINES_SVH
`define MIDI_NOTE_PAIRING_ENGINE_DEFINES_SVH
`ifndef SYNTHESIS
`define MNP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define MNP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define MNP_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define MNP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[rtl/mnp_pkg.sv]
// Package with types, constants and helpers of the MIDI note pairing engine.
`timescale 1ns / 1ps
package mnp_pkg;
  localparam int Ports = 16;
  localparam int PortW = $clog2(Ports) > 0 ? $clog2(Ports) : 1;
  localparam int KeyW = PortW + 11;
  localparam int TableDepth = Ports * 2048;
  localparam int NoteCapacity = 65536;
  localparam int NiW = $clog2(NoteCapacity) + 1;
  localparam int EntryW = 1 + NiW - 1;
  localparam logic [23:0] TempoReset = 24'd500000;

  // Milliseconds are taken as floor(floor(us / 8) / 125); the second step multiplies by
  // the reciprocal of 125 scaled by 2^46 and rounded up.
  localparam logic [39:0] MsRecip = 40'd562949953422;
  localparam logic [12:0] MsSatHigh = 13'd125;

  localparam logic [2:0] ModeNoteOn = 3'd0;
  localparam logic [2:0] ModeNoteOff = 3'd1;
  localparam logic [2:0] ModeTempo = 3'd2;
  localparam logic [2:0] ModeFlush = 3'd4;

  localparam logic [2:0] CfgPortEn = 3'd0;
  localparam logic [2:0] CfgPort = 3'd1;
  localparam logic [2:0] CfgChanEn = 3'd2;
  localparam logic [2:0] CfgChan = 3'd3;
  localparam logic [2:0] CfgTpq = 3'd4;

  typedef struct packed {
    logic [2:0]  mode;
    logic [27:0] delta_time;
    logic [3:0]  port;
    logic [3:0]  channel;
    logic [6:0]  note_number;
    logic [6:0]  velocity;
    logic [23:0] tempo_value;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [15:0] note_index;
    logic [3:0]  out_port;
    logic [3:0]  out_channel;
    logic [6:0]  out_note;
    logic [6:0]  out_velocity;
    logic [31:0] event_time;
    logic        status;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [14:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quotient;
    logic [14:0] remainder;
  } div_rsp_t;
endpackage

[rtl/mnp_ram.sv]
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
module mnp_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

[rtl/mnp_divider.sv]
// Iterative radix-2 divider of a 64-bit dividend by a 15-bit divisor.
`timescale 1ns / 1ps
module mnp_divider (
  input  logic              clk,
  input  logic              rst_n,
  input  mnp_pkg::div_req_t req,
  output mnp_pkg::div_rsp_t rsp
);
  logic [63:0] quo_r, quo_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic [14:0] dvs_r, dvs_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [15:0] trial;

  always_comb begin
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    dvs_nxt = dvs_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial = {rem_r[14:0], quo_r[63]};
    if (req.start) begin
      quo_nxt = req.dividend;
      rem_nxt = '0;
      dvs_nxt = req.divisor;
      cnt_nxt = 7'd0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = trial - {1'b0, dvs_r};
        quo_nxt = {quo_r[62:0], 1'b1};
      end else begin
        rem_nxt = trial;
        quo_nxt = {quo_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r + 7'd1;
      if (cnt_r == 7'd63) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quotient = quo_r;
  assign rsp.remainder = rem_r[14:0];
endmodule

[rtl/midi_note_pairing_engine.sv]
// Top level of the MIDI note pairing engine: timing, active table and result queue.
//
//   Channel  Direction  Handshake           Payload
//   in       input      in_valid/in_stall   mnp_pkg::in_item_t
//   out      output     out_valid/out_stall mnp_pkg::out_item_t
//   cfg      input      cfg_we              cfg_index, cfg_data
//
// With ticks_per_quarter nonzero an item takes two passes of the 64-step divider
// (quotient and fraction of delta*tempo/tpq), four reciprocal multiply steps for
// milliseconds, the table read and the output of each result.
// In tick mode an item skips the divider and goes from input straight to the table read.
// After reset the table is cleared one entry a cycle, all 32768 entries, with no input taken.
// A stalled result holds; the next item is taken only once all results leave.
`timescale 1ns / 1ps
`include "midi_note_pairing_engine_defines.svh"
module midi_note_pairing_engine (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  mnp_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output mnp_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [14:0]        cfg_data
);
  typedef enum logic [8:0] {
    S_CLEAR = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_DIV1  = 9'b000000100,
    S_DIV2  = 9'b000001000,
    S_ADD   = 9'b000010000,
    S_MS    = 9'b000100000,
    S_READ  = 9'b001000000,
    S_ACT   = 9'b010000000,
    S_EMIT  = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  logic        pen_r, cen_r;
  logic [3:0]  pov_r, cov_r;
  logic [14:0] tpq_r;

  mnp_pkg::in_item_t item_r, item_nxt;
  logic [31:0] ticks_r, ticks_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [23:0] tempo_r, tempo_nxt;
  logic [mnp_pkg::NiW-1:0] next_idx_r, next_idx_nxt;
  logic [63:0] q_r, q_nxt;
  logic [51:0] prod_r, prod_nxt;
  logic [31:0] time_r, time_nxt;
  logic [mnp_pkg::KeyW-1:0] clr_r, clr_nxt;
  logic [39:0] ms_y_r, ms_y_nxt;
  logic [79:0] ms_p_r, ms_p_nxt;
  logic [1:0]  ms_cnt_r, ms_cnt_nxt;
  logic        ms_sat_r, ms_sat_nxt;

  mnp_pkg::out_item_t res0_r, res0_nxt, res1_r, res1_nxt;
  logic [1:0] res_cnt_r, res_cnt_nxt;
  logic       res_sel_r, res_sel_nxt;

  mnp_pkg::div_req_t div_req;
  mnp_pkg::div_rsp_t div_rsp;

  logic [3:0] eff_port, eff_chan;
  logic [mnp_pkg::KeyW-1:0] key;
  logic ram_we;
  logic [mnp_pkg::KeyW-1:0] ram_addr;
  logic [mnp_pkg::EntryW-1:0] ram_wdata, ram_rdata;
  logic [64:0] sum;
  logic [63:0] inc;
  logic [49:0] ms_pp;
  logic [79:0] ms_step;
  logic full;

  mnp_divider u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp));

  mnp_ram #(.Width(mnp_pkg::EntryW), .Depth(mnp_pkg::TableDepth)) u_table (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pen_r <= 1'b0;
      pov_r <= '0;
      cen_r <= 1'b0;
      cov_r <= '0;
      tpq_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mnp_pkg::CfgPortEn: pen_r <= cfg_data[0];
        mnp_pkg::CfgPort:   pov_r <= cfg_data[3:0];
        mnp_pkg::CfgChanEn: cen_r <= cfg_data[0];
        mnp_pkg::CfgChan:   cov_r <= cfg_data[3:0];
        mnp_pkg::CfgTpq:    tpq_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign eff_port = pen_r ? pov_r : item_r.port;
  assign eff_chan = cen_r ? cov_r : item_r.channel;
  assign key = {eff_port[mnp_pkg::PortW-1:0], eff_chan, item_r.note_number};
  assign full = next_idx_r[mnp_pkg::NiW-1];
  assign inc = {q_r[47:0], 16'd0} + {48'd0, div_rsp.quotient[15:0]};
  assign sum = {1'b0, acc_r} + {1'b0, inc};
  assign ms_pp = {40'd0, ms_y_r[39:30]} * {10'd0, mnp_pkg::MsRecip};
  assign ms_step = {ms_p_r[69:0], 10'd0} + {30'd0, ms_pp};

  assign in_stall = (state_r != S_IDLE);
  assign out_valid = (state_r == S_EMIT);
  assign out_data = res_sel_r ? res1_r : res0_r;

  always_comb begin
    state_nxt = state_r;
    item_nxt = item_r;
    ticks_nxt = ticks_r;
    acc_nxt = acc_r;
    tempo_nxt = tempo_r;
    next_idx_nxt = next_idx_r;
    q_nxt = q_r;
    prod_nxt = prod_r;
    time_nxt = time_r;
    clr_nxt = clr_r;
    ms_y_nxt = ms_y_r;
    ms_p_nxt = ms_p_r;
    ms_cnt_nxt = ms_cnt_r;
    ms_sat_nxt = ms_sat_r;
    res0_nxt = res0_r;
    res1_nxt = res1_r;
    res_cnt_nxt = res_cnt_r;
    res_sel_nxt = res_sel_r;
    div_req = '0;
    ram_we = 1'b0;
    ram_addr = key;
    ram_wdata = '0;
    unique case (state_r)
      S_CLEAR: begin
        ram_we = 1'b1;
        ram_addr = clr_r;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == mnp_pkg::KeyW'(mnp_pkg::TableDepth - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          item_nxt = in_data;
          ticks_nxt = ticks_r + {4'd0, in_data.delta_time};
          prod_nxt = 52'(in_data.delta_time) * 52'(tempo_r);
          if (tpq_r == '0) begin
            time_nxt = ticks_r + {4'd0, in_data.delta_time};
            state_nxt = S_READ;
          end else begin
            state_nxt = S_DIV1;
          end
        end
      end
      S_DIV1: begin
        div_req.start = 1'b1;
        div_req.dividend = {12'd0, prod_r};
        div_req.divisor = tpq_r;
        state_nxt = S_DIV2;
      end
      S_DIV2: begin
        if (div_rsp.done) begin
          q_nxt = div_rsp.quotient;
          div_req.start = 1'b1;
          div_req.dividend = {33'd0, div_rsp.remainder, 16'd0};
          div_req.divisor = tpq_r;
          state_nxt = S_ADD;
        end
      end
      S_ADD: begin
        if (div_rsp.done) begin
          if (q_r[63:48] != 16'd0 || sum[64]) begin
            acc_nxt = '1;
          end else begin
            acc_nxt = sum[63:0];
          end
          ms_sat_nxt = (acc_nxt[63:51] >= mnp_pkg::MsSatHigh);
          ms_y_nxt = {1'b0, acc_nxt[57:19]};
          ms_p_nxt = '0;
          ms_cnt_nxt = '0;
          state_nxt = S_MS;
        end
      end
      S_MS: begin
        ms_p_nxt = ms_step;
        ms_y_nxt = {ms_y_r[29:0], 10'd0};
        ms_cnt_nxt = ms_cnt_r + 2'd1;
        if (ms_cnt_r == 2'd3) begin
          time_nxt = ms_sat_r ? '1 : ms_step[77:46];
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        state_nxt = S_ACT;
      end
      S_ACT: begin
        res_cnt_nxt = 2'd0;
        res_sel_nxt = 1'b0;
        res0_nxt = '0;
        res1_nxt = '0;
        res0_nxt.out_port = eff_port;
        res0_nxt.out_channel = eff_chan;
        res0_nxt.out_note = item_r.note_number;
        res0_nxt.event_time = time_r;
        res1_nxt = res0_nxt;
        if (item_r.mode == mnp_pkg::ModeTempo) begin
          tempo_nxt = item_r.tempo_value;
          state_nxt = S_IDLE;
        end else if (item_r.mode == mnp_pkg::ModeNoteOn) begin
          res0_nxt.kind = 1'b1;
          res0_nxt.note_index = ram_rdata[15:0];
          res1_nxt.out_velocity = item_r.velocity;
          res1_nxt.last = 1'b1;
          if (full) begin
            res1_nxt.status = 1'b1;
            ram_we = ram_rdata[mnp_pkg::EntryW-1];
            ram_wdata = '0;
          end else begin
            res1_nxt.note_index = next_idx_r[15:0];
            ram_we = 1'b1;
            ram_wdata = {1'b1, next_idx_r[15:0]};
            next_idx_nxt = next_idx_r + 1'b1;
          end
          if (ram_rdata[mnp_pkg::EntryW-1]) begin
            res_cnt_nxt = 2'd2;
          end else begin
            res_cnt_nxt = 2'd1;
            res0_nxt = res1_nxt;
          end
          state_nxt = S_EMIT;
        end else if ((item_r.mode == mnp_pkg::ModeNoteOff ||
                      item_r.mode == mnp_pkg::ModeFlush) && ram_rdata[mnp_pkg::EntryW-1]) begin
          res0_nxt.kind = 1'b1;
          res0_nxt.note_index = ram_rdata[15:0];
          res0_nxt.last = 1'b1;
          res_cnt_nxt = 2'd1;
          ram_we = 1'b1;
          ram_wdata = '0;
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_EMIT: begin
        if (!out_stall) begin
          if (res_cnt_r == 2'd2 && !res_sel_r) begin
            res_sel_nxt = 1'b1;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r <= '0;
      ticks_r <= '0;
      acc_r <= '0;
      tempo_r <= mnp_pkg::TempoReset;
      next_idx_r <= '0;
      res_cnt_r <= '0;
      res_sel_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r <= clr_nxt;
      ticks_r <= ticks_nxt;
      acc_r <= acc_nxt;
      tempo_r <= tempo_nxt;
      next_idx_r <= next_idx_nxt;
      res_cnt_r <= res_cnt_nxt;
      res_sel_r <= res_sel_nxt;
    end
    item_r <= item_nxt;
    q_r <= q_nxt;
    prod_r <= prod_nxt;
    time_r <= time_nxt;
    ms_y_r <= ms_y_nxt;
    ms_p_r <= ms_p_nxt;
    ms_cnt_r <= ms_cnt_nxt;
    ms_sat_r <= ms_sat_nxt;
    res0_r <= res0_nxt;
    res1_r <= res1_nxt;
  end

  `MNP_ASSERT_IMPL(a_out_idle_exclusive, clk, rst_n, out_valid, in_stall)
  `MNP_ASSERT_IMPL(a_sel_needs_two, clk, rst_n, out_valid && res_sel_r, res_cnt_r == 2'd2)
  `MNP_ASSERT_NEXT(a_index_monotonic, clk, rst_n, state_r == S_IDLE, next_idx_r >= $past(next_idx_r))
endmodule

[bench/midi_note_pairing_engine_tb.sv]
// Self-checking testbench for the MIDI note pairing engine, predicted from a behavioral model.
`timescale 1ns / 1ps
module midi_note_pairing_engine_tb;

  localparam logic [2:0] ModeOther = 3'd3;
  localparam logic [2:0] ModeSpareLo = 3'd5;
  localparam logic [2:0] ModeSpareHi = 3'd7;
  localparam int DrainCycles = 200;
  localparam int HoldCycles = 400;
  localparam int WatchdogLimit = 200000;

  typedef struct {
    mnp_pkg::in_item_t  item;
    bit                 typed;
    mnp_pkg::out_item_t result;
  } stim_row_t;

  logic      clk;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  mnp_pkg::in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  mnp_pkg::out_item_t out_data;
  logic       cfg_we = 1'b0;
  logic [2:0] cfg_index = mnp_pkg::CfgPortEn;
  logic [14:0] cfg_data = '0;

  // Predictor state.
  bit          key_active [mnp_pkg::TableDepth];
  logic [16:0] key_note [mnp_pkg::TableDepth];
  logic [31:0] tick_count;
  logic [63:0] usec_acc;
  logic [23:0] tempo_now;
  logic [16:0] note_count;
  logic        port_ovr_en, chan_ovr_en;
  logic [3:0]  port_ovr, chan_ovr;
  logic [14:0] tick_div;

  mnp_pkg::out_item_t expected_events[$];
  stim_row_t dir_rows[$];
  bit  idle_en = 1'b1;
  bit  hold_req = 1'b0;
  int  mismatches = 0;
  int  items_sent = 0;
  int  events_seen = 0;
  int  full_seen = 0;
  int  retrig_seen = 0;
  bit  done = 1'b0;

  midi_note_pairing_engine i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic mnp_pkg::in_item_t make_item(logic [2:0] m, logic [27:0] d,
                                                  logic [3:0] p, logic [3:0] c,
                                                  logic [6:0] n, logic [6:0] v,
                                                  logic [23:0] t);
    mnp_pkg::in_item_t x;
    x.mode = m;
    x.delta_time = d;
    x.port = p;
    x.channel = c;
    x.note_number = n;
    x.velocity = v;
    x.tempo_value = t;
    return x;
  endfunction

  function automatic mnp_pkg::out_item_t make_event(logic k, logic [15:0] idx, logic [3:0] p,
                                                    logic [3:0] c, logic [6:0] n,
                                                    logic [6:0] v, logic [31:0] t,
                                                    logic st);
    mnp_pkg::out_item_t e;
    e.kind = k;
    e.note_index = idx;
    e.out_port = p;
    e.out_channel = c;
    e.out_note = n;
    e.out_velocity = v;
    e.event_time = t;
    e.status = st;
    e.last = 1'b0;
    return e;
  endfunction

  task automatic reset_model();
    foreach (key_active[i]) key_active[i] = 1'b0;
    tick_count = '0;
    usec_acc = '0;
    tempo_now = mnp_pkg::TempoReset;
    note_count = '0;
    port_ovr_en = 1'b0;
    chan_ovr_en = 1'b0;
    port_ovr = '0;
    chan_ovr = '0;
    tick_div = '0;
  endtask

  // Advances time, updates the tempo and the active table and returns the note events of one transaction.
  task automatic pair_notes(input mnp_pkg::in_item_t x, output mnp_pkg::out_item_t ev[2],
                            output int cnt);
    logic [63:0] prod, quo, rem, inc, msec;
    logic [31:0] t;
    logic [3:0]  p, c;
    logic [14:0] key;
    cnt = 0;
    p = port_ovr_en ? port_ovr : x.port;
    c = chan_ovr_en ? chan_ovr : x.channel;
    tick_count = tick_count + 32'(x.delta_time);
    if (tick_div != 0) begin
      prod = 64'(x.delta_time) * 64'(tempo_now);
      quo = prod / 64'(tick_div);
      rem = prod % 64'(tick_div);
      if (quo >= (64'd1 << 48)) begin
        usec_acc = '1;
      end else begin
        inc = (quo << 16) + ((rem << 16) / 64'(tick_div));
        usec_acc = (usec_acc > ~inc) ? '1 : usec_acc + inc;
      end
      msec = (usec_acc >> 16) / 64'd1000;
      t = (msec > 64'hFFFF_FFFF) ? '1 : msec[31:0];
    end else begin
      t = tick_count;
    end
    key = {p, c, x.note_number};
    if (x.mode == mnp_pkg::ModeTempo) begin
      tempo_now = x.tempo_value;
    end else if (x.mode == mnp_pkg::ModeNoteOn || x.mode == mnp_pkg::ModeNoteOff ||
                 x.mode == mnp_pkg::ModeFlush) begin
      if (key_active[key]) begin
        ev[cnt] = make_event(1'b1, key_note[key][15:0], p, c, x.note_number, '0, t, 1'b0);
        cnt++;
        key_active[key] = 1'b0;
      end
      if (x.mode == mnp_pkg::ModeNoteOn) begin
        if (note_count >= 17'(mnp_pkg::NoteCapacity)) begin
          ev[cnt] = make_event(1'b0, '0, p, c, x.note_number, x.velocity, t, 1'b1);
        end else begin
          ev[cnt] = make_event(1'b0, note_count[15:0], p, c, x.note_number, x.velocity, t,
                               1'b0);
          key_active[key] = 1'b1;
          key_note[key] = note_count;
          note_count++;
        end
        cnt++;
      end
    end
    if (cnt > 0) ev[cnt-1].last = 1'b1;
  endtask

  task automatic send_item(input mnp_pkg::in_item_t x, input bit typed = 1'b0,
                           input mnp_pkg::out_item_t typed_ev = '0);
    mnp_pkg::out_item_t ev[2];
    int cnt;
    if (idle_en && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= x;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    pair_notes(x, ev, cnt);
    if (cnt == 2) retrig_seen++;
    if (typed) begin
      expected_events.push_back(typed_ev);
    end else begin
      for (int i = 0; i < cnt; i++) expected_events.push_back(ev[i]);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [14:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      mnp_pkg::CfgPortEn: port_ovr_en = val[0];
      mnp_pkg::CfgPort:   port_ovr = val[3:0];
      mnp_pkg::CfgChanEn: chan_ovr_en = val[0];
      mnp_pkg::CfgChan:   chan_ovr = val[3:0];
      mnp_pkg::CfgTpq:    tick_div = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic configure(input logic pe, input logic [3:0] pv, input logic ce,
                           input logic [3:0] cv, input logic [14:0] tpq);
    write_reg(mnp_pkg::CfgPortEn, {14'd0, pe});
    write_reg(mnp_pkg::CfgPort, {11'd0, pv});
    write_reg(mnp_pkg::CfgChanEn, {14'd0, ce});
    write_reg(mnp_pkg::CfgChan, {11'd0, cv});
    write_reg(mnp_pkg::CfgTpq, tpq);
  endtask

  function automatic mnp_pkg::in_item_t random_item();
    mnp_pkg::in_item_t x;
    int sel;
    x.port = 4'($urandom_range(0, 15));
    x.channel = 4'($urandom_range(0, 15));
    // A small key pool keeps note-ons and note-offs meeting each other.
    x.note_number = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127))
                                                : 7'($urandom_range(60, 63));
    if ($urandom_range(0, 1) == 0) x.port = 4'($urandom_range(0, 1));
    if ($urandom_range(0, 1) == 0) x.channel = 4'($urandom_range(0, 1));
    x.velocity = 7'($urandom_range(0, 127));
    x.tempo_value = 24'($urandom_range(0, 24'hFFFFFF));
    sel = $urandom_range(0, 99);
    if (sel < 40) x.mode = mnp_pkg::ModeNoteOn;
    else if (sel < 73) x.mode = mnp_pkg::ModeNoteOff;
    else if (sel < 81) x.mode = mnp_pkg::ModeTempo;
    else if (sel < 88) x.mode = ModeOther;
    else if (sel < 96) x.mode = mnp_pkg::ModeFlush;
    else x.mode = 3'($urandom_range(int'(ModeSpareLo), int'(ModeSpareHi)));
    sel = $urandom_range(0, 9);
    if (sel < 6) x.delta_time = 28'($urandom_range(0, 100));
    else if (sel < 9) x.delta_time = 28'($urandom_range(0, 2000));
    else x.delta_time = 28'($urandom_range(0, 28'hFFFFFFF));
    return x;
  endfunction

  task automatic random_run(input int n);
    for (int i = 0; i < n; i++) begin
      if (i == n / 3 && idle_en) hold_req = 1'b1;
      if (i == 2 * n / 3) drain();
      send_item(random_item());
    end
  endtask

  // Result checker and receiver stall generator.
  initial begin
    int hold_left;
    int stall_left;
    mnp_pkg::out_item_t e;
    hold_left = 0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        events_seen++;
        if (out_data.status) full_seen++;
        if (expected_events.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Unexpected note event: %p", out_data);
        end else begin
          e = expected_events.pop_front();
          if (out_data.kind !== e.kind || out_data.note_index !== e.note_index ||
              out_data.out_port !== e.out_port || out_data.out_channel !== e.out_channel ||
              out_data.out_note !== e.out_note || out_data.out_velocity !== e.out_velocity ||
              out_data.event_time !== e.event_time || out_data.status !== e.status ||
              out_data.last !== e.last) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("Note event mismatch:");
              $display("  expected %p", e);
              $display("  actual   %p", out_data);
            end
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HoldCycles;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (idle_en && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 14) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog on cycles without any transaction.
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
      if (quiet >= WatchdogLimit && !done) begin
        $display("Timeout: no transaction for %0d cycles", quiet);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    stim_row_t r;
    reset_model();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part in tick mode.
    r.typed = 1'b1;
    r.item = make_item(mnp_pkg::ModeNoteOn, 28'd5, 4'd0, 4'd0, 7'd0, 7'd127, 24'd0);
    r.result = make_event(1'b0, 16'd0, 4'd0, 4'd0, 7'd0, 7'd127, 32'd5, 1'b0);
    r.result.last = 1'b1;
    dir_rows.push_back(r);
    r.typed = 1'b0;
    r.result = '0;
    r.item = make_item(mnp_pkg::ModeNoteOn, 28'd0, 4'd0, 4'd0, 7'd0, 7'd0, 24'd0);
    dir_rows.push_back(r);
    r.item = make_item(mnp_pkg::ModeNoteOff, 28'd3, 4'd0, 4'd0, 7'd0, 7'd0, 24'd0);
    dir_rows.push_back(r);
    r.item = make_item(mnp_pkg::ModeNoteOff, 28'd1, 4'd0, 4'd0, 7'd0, 7'd0, 24'd0);
    dir_rows.push_back(r);
    r.item = make_item(mnp_pkg::ModeNoteOn, 28'hFFFFFFF, 4'd15, 4'd15, 7'd127, 7'd1,
                       24'hFFFFFF);
    dir_rows.push_back(r);
    r.item = make_item(mnp_pkg::ModeFlush, 28'hFFFFFFF, 4'd15, 4'd15, 7'd127, 7'd127,
                       24'hFFFFFF);
    dir_rows.push_back(r);
    r.item = make_item(mnp_pkg::ModeFlush, 28'd0, 4'd15, 4'd15, 7'd127, 7'd0, 24'd0);
    dir_rows.push_back(r);
    r.item = make_item(mnp_pkg::ModeTempo, 28'd7, 4'd3, 4'd3, 7'd3, 7'd3, 24'hFFFFFF);
    dir_rows.push_back(r);
    r.item = make_item(ModeOther, 28'hFFFFFFF, 4'd9, 4'd9, 7'd9, 7'd9, 24'd0);
    dir_rows.push_back(r);
    for (int m = int'(ModeSpareLo); m <= int'(ModeSpareHi); m++) begin
      r.item = make_item(3'(m), 28'hFFFFFFF, 4'd1, 4'd1, 7'd1, 7'd1, 24'd1);
      dir_rows.push_back(r);
    end
    for (int i = 0; i < 12; i++) begin
      r.item = make_item(ModeOther, 28'hFFFFFFF, 4'd0, 4'd0, 7'd0, 7'd0, 24'd0);
      dir_rows.push_back(r);
    end
    r.item = make_item(mnp_pkg::ModeNoteOn, 28'd1, 4'd10, 4'd5, 7'd64, 7'd100, 24'd0);
    dir_rows.push_back(r);
    foreach (dir_rows[i]) send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].result);
    drain();
    random_run(300);
    drain();

    // Overrides on, smallest nonzero division, so the microsecond count saturates.
    configure(1'b1, 4'd15, 1'b1, 4'd0, 15'd1);
    random_run(250);
    drain();

    configure(1'b0, 4'd0, 1'b1, 4'd15, 15'd32767);
    send_item(make_item(mnp_pkg::ModeTempo, 28'd0, 4'd0, 4'd0, 7'd0, 7'd0, 24'hFFFFFF));
    random_run(250);
    drain();

    configure(1'b1, 4'd7, 1'b0, 4'd9, 15'd480);
    random_run(250);
    drain();

    // Last part: no idling, tick mode, back to back transactions.
    idle_en = 1'b0;
    configure(1'b0, 4'd0, 1'b0, 4'd0, 15'd0);
    random_run(200);
    send_item(make_item(mnp_pkg::ModeNoteOn, 28'd1, 4'd0, 4'd0, 7'd0, 7'd5, 24'd0));
    send_item(make_item(mnp_pkg::ModeNoteOn, 28'd1, 4'd0, 4'd0, 7'd0, 7'd6, 24'd0));
    send_item(make_item(mnp_pkg::ModeNoteOff, 28'd1, 4'd0, 4'd0, 7'd1, 7'd0, 24'd0));
    send_item(make_item(mnp_pkg::ModeNoteOn, 28'd1, 4'd0, 4'd0, 7'd1, 7'd7, 24'd0));
    drain();
    done = 1'b1;

    $display("Sent %0d transactions, checked %0d note events (%0d retriggers, %0d list-full).",
             items_sent, events_seen, retrig_seen, full_seen);
    $display("Covered tick and millisecond timing, saturation, overrides and flushes.");
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
